// ----- rtl/cvps_pkg.sv -----
package cvps_pkg;

  localparam int unsigned DROP_W     = 32;
  localparam int unsigned PRESS_W    = 31;
  localparam int unsigned RATE_W     = 24;
  localparam int unsigned DT_W       = 21;
  localparam int unsigned DT_CNT_W   = 5;
  localparam int unsigned DT_FRAC    = 20;
  localparam int unsigned POS_W      = 17;
  localparam int unsigned PROD_W     = RATE_W + DT_W;
  localparam int unsigned MD_W       = PROD_W - DT_FRAC;
  localparam int unsigned LIM_W      = MD_W + 1;

  localparam int unsigned SER_W      = 34;
  localparam int unsigned SER_CNT_W  = 6;

  localparam int unsigned QUO_W      = 15;
  localparam int unsigned QUO_CNT_W  = 4;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 31;

  localparam int unsigned S_TDATA_W  = 88;
  localparam int unsigned M_TDATA_W  = 24;
  localparam int unsigned M_TUSER_W  = 1;

  localparam logic [POS_W-1:0]   POS_FULL = 17'd65536;
  localparam logic [POS_W-1:0]   POS_HALF = 17'd32768;

  localparam logic [PRESS_W-1:0] OPEN_PRESSURE_RST = 31'd25600;
  localparam logic [PRESS_W-1:0] DEADBAND_RST      = 31'd256;
  localparam logic [RATE_W-1:0]  RATE_LIMIT_RST    = 24'd65536;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SERIAL,
    ST_DECIDE,
    ST_DIVIDE,
    ST_TARGET,
    ST_LIMIT
  } state_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATH_B_OPEN      = 3'd0,
    CFG_OPEN_PRESSURE_A  = 3'd1,
    CFG_OPEN_PRESSURE_B  = 3'd2,
    CFG_DEADBAND         = 3'd3,
    CFG_RATE_LIMIT       = 3'd4,
    CFG_STUCK_ENABLE     = 3'd5,
    CFG_FAIL_TO_ENABLE   = 3'd6,
    CFG_FAIL_TO_POSITION = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic hold;
    logic ge_db;
    logic pos;
    logic zero;
    logic sat;
  } flags_t;

endpackage

// ----- rtl/cvps_bitsub.sv -----
module cvps_bitsub (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        clr_i,
  input  logic                        en_i,
  input  logic                        x_i,
  input  logic                        y_i,
  output logic                        bit_o,
  output logic [cvps_pkg::SER_W-1:0]  word_o
);

  logic                       borrow_q, borrow_d;
  logic [cvps_pkg::SER_W-1:0] word_q, word_d;

  assign bit_o = x_i ^ y_i ^ borrow_q;

  always_comb begin
    borrow_d = borrow_q;
    word_d   = word_q;
    if (clr_i) begin
      borrow_d = 1'b0;
    end else if (en_i) begin
      borrow_d = (~x_i & y_i) | (~(x_i ^ y_i) & borrow_q);
      word_d   = {bit_o, word_q[cvps_pkg::SER_W-1:1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      borrow_q <= 1'b0;
    end else begin
      borrow_q <= borrow_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

endmodule

// ----- rtl/cvps_mul.sv -----
module cvps_mul (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [cvps_pkg::RATE_W-1:0]  rate_i,
  input  logic [cvps_pkg::DT_W-1:0]    dt_i,
  output logic [cvps_pkg::PROD_W-1:0]  prod_o
);

  logic                            run_q, run_d;
  logic [cvps_pkg::DT_CNT_W-1:0]   cnt_q, cnt_d;
  logic [cvps_pkg::PROD_W-1:0]     prod_q, prod_d;
  logic [cvps_pkg::RATE_W:0]       sum;

  // shift-add, one multiplier bit per cycle, lsb first
  always_comb begin
    sum    = {1'b0, prod_q[cvps_pkg::PROD_W-1:cvps_pkg::DT_W]}
           + (prod_q[0] ? {1'b0, rate_i} : '0);
    run_d  = run_q;
    cnt_d  = cnt_q;
    prod_d = prod_q;
    if (start_i) begin
      run_d  = 1'b1;
      cnt_d  = '0;
      prod_d = {{cvps_pkg::RATE_W{1'b0}}, dt_i};
    end else if (run_q) begin
      prod_d = {sum, prod_q[cvps_pkg::DT_W-1:1]};
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == cvps_pkg::DT_CNT_W'(cvps_pkg::DT_W - 1)) begin
        run_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      run_q <= run_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign prod_o = prod_q;

endmodule

// ----- rtl/cvps_div.sv -----
module cvps_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [cvps_pkg::PRESS_W-1:0]  num_i,
  input  logic [cvps_pkg::PRESS_W-1:0]  den_i,
  output logic                          busy_o,
  output logic [cvps_pkg::QUO_W-1:0]    quo_o
);

  logic                             busy_q, busy_d;
  logic [cvps_pkg::QUO_CNT_W-1:0]   cnt_q, cnt_d;
  logic [cvps_pkg::PRESS_W-1:0]     rem_q, rem_d;
  logic [cvps_pkg::PRESS_W-1:0]     den_q, den_d;
  logic [cvps_pkg::QUO_W-1:0]       quo_q, quo_d;
  logic [cvps_pkg::PRESS_W:0]       shifted;
  logic [cvps_pkg::PRESS_W:0]       trial;
  logic                             fits;

  // restoring division, one quotient bit per cycle; num < den on entry
  always_comb begin
    shifted = {rem_q, 1'b0};
    trial   = shifted - {1'b0, den_q};
    fits    = shifted >= {1'b0, den_q};
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    den_d   = den_q;
    quo_d   = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = num_i;
      den_d  = den_i;
    end else if (busy_q) begin
      rem_d = fits ? trial[cvps_pkg::PRESS_W-1:0] : shifted[cvps_pkg::PRESS_W-1:0];
      quo_d = {quo_q[cvps_pkg::QUO_W-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == cvps_pkg::QUO_CNT_W'(cvps_pkg::QUO_W - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;

endmodule

// ----- rtl/check_valve_position_step.sv -----
// an item runs through the bit-serial subtract pass over the drops and
// pressures, the branch decision, the divide when the target needs it, the
// target and the rate clamp; the next item is taken only once it is done.
// the shared restoring divider adds one quotient bit per cycle.
// rst_ni clears the registers to their reset values and the position to
// half open; no item is taken while reset is low.
module check_valve_position_step (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // drop_a [31:0], drop_b [63:32], time_step [84:64]
  input  logic [cvps_pkg::S_TDATA_W-1:0]    s_axis_tdata_i,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // position [16:0]
  output logic [cvps_pkg::M_TDATA_W-1:0]    m_axis_tdata_o,
  // backflow_hold [0]
  output logic [cvps_pkg::M_TUSER_W-1:0]    m_axis_tuser_o,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  input  logic                              cfg_we_i,
  input  logic [cvps_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [cvps_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int unsigned SW = cvps_pkg::SER_W;
  localparam int unsigned PW = cvps_pkg::POS_W;

  // configuration
  logic                          path_b_open_q;
  logic [cvps_pkg::PRESS_W-1:0]  open_pressure_a_q;
  logic [cvps_pkg::PRESS_W-1:0]  open_pressure_b_q;
  logic [cvps_pkg::PRESS_W-1:0]  deadband_q;
  logic [cvps_pkg::RATE_W-1:0]   rate_limit_q;
  logic                          stuck_enable_q;
  logic                          fail_to_enable_q;
  logic [PW-1:0]                 fail_to_position_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      path_b_open_q      <= 1'b0;
      open_pressure_a_q  <= cvps_pkg::OPEN_PRESSURE_RST;
      open_pressure_b_q  <= cvps_pkg::OPEN_PRESSURE_RST;
      deadband_q         <= cvps_pkg::DEADBAND_RST;
      rate_limit_q       <= cvps_pkg::RATE_LIMIT_RST;
      stuck_enable_q     <= 1'b0;
      fail_to_enable_q   <= 1'b0;
      fail_to_position_q <= '0;
    end else if (cfg_we_i) begin
      case (cvps_pkg::cfg_idx_e'(cfg_idx_i))
        cvps_pkg::CFG_PATH_B_OPEN:      path_b_open_q      <= cfg_data_i[0];
        cvps_pkg::CFG_OPEN_PRESSURE_A:  open_pressure_a_q  <= cfg_data_i;
        cvps_pkg::CFG_OPEN_PRESSURE_B:  open_pressure_b_q  <= cfg_data_i;
        cvps_pkg::CFG_DEADBAND:         deadband_q         <= cfg_data_i;
        cvps_pkg::CFG_RATE_LIMIT:       rate_limit_q       <= cfg_data_i[cvps_pkg::RATE_W-1:0];
        cvps_pkg::CFG_STUCK_ENABLE:     stuck_enable_q     <= cfg_data_i[0];
        cvps_pkg::CFG_FAIL_TO_ENABLE:   fail_to_enable_q   <= cfg_data_i[0];
        cvps_pkg::CFG_FAIL_TO_POSITION: fail_to_position_q <= cfg_data_i[PW-1:0];
        default: ;
      endcase
    end
  end

  // control
  cvps_pkg::state_e                state_q, state_d;
  logic [cvps_pkg::SER_CNT_W-1:0]  ser_cnt_q, ser_cnt_d;
  logic                            s_fire;
  logic                            ser_en;
  logic                            div_start;
  logic                            div_busy;
  logic                            out_free;
  logic                            lim_fire;

  logic [cvps_pkg::DROP_W-1:0]     drop_a;
  logic [cvps_pkg::DROP_W-1:0]     drop_b;
  logic [cvps_pkg::DT_W-1:0]       time_step;

  assign drop_a    = s_axis_tdata_i[31:0];
  assign drop_b    = s_axis_tdata_i[63:32];
  assign time_step = s_axis_tdata_i[84:64];

  assign s_axis_tready_o = (state_q == cvps_pkg::ST_IDLE);
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;
  assign ser_en          = (state_q == cvps_pkg::ST_SERIAL);
  assign out_free        = !m_axis_tvalid_o || m_axis_tready_i;

  // operand shift lines, lsb first
  logic [SW-1:0] sa_q, sa_d;
  logic [SW-1:0] sb_q, sb_d;
  logic [SW-1:0] sd_q, sd_d;
  logic [SW-1:0] soa_q, soa_d;
  logic [SW-1:0] sob_q, sob_d;

  always_comb begin
    sa_d  = sa_q;
    sb_d  = sb_q;
    sd_d  = sd_q;
    soa_d = soa_q;
    sob_d = sob_q;
    if (s_fire) begin
      sa_d  = {{(SW - cvps_pkg::DROP_W){drop_a[cvps_pkg::DROP_W-1]}}, drop_a};
      sb_d  = {{(SW - cvps_pkg::DROP_W){drop_b[cvps_pkg::DROP_W-1]}}, drop_b};
      sd_d  = {{(SW - cvps_pkg::PRESS_W){1'b0}}, deadband_q};
      soa_d = {{(SW - cvps_pkg::PRESS_W){1'b0}}, open_pressure_a_q};
      sob_d = {{(SW - cvps_pkg::PRESS_W){1'b0}}, open_pressure_b_q};
    end else if (ser_en) begin
      sa_d  = {1'b0, sa_q[SW-1:1]};
      sb_d  = {1'b0, sb_q[SW-1:1]};
      sd_d  = {1'b0, sd_q[SW-1:1]};
      soa_d = {1'b0, soa_q[SW-1:1]};
      sob_d = {1'b0, sob_q[SW-1:1]};
    end
  end

  always_ff @(posedge clk_i) begin
    sa_q  <= sa_d;
    sb_q  <= sb_d;
    sd_q  <= sd_d;
    soa_q <= soa_d;
    sob_q <= sob_d;
  end

  // serial subtractors
  logic          ab_bit, ba_bit;
  logic [SW-1:0] ab_word;
  logic [SW-1:0] abd_word, bad_word;
  logic [SW-1:0] dena_word, denb_word;

  // a - b
  cvps_bitsub u_ab (
    .clk_i, .rst_ni, .clr_i(s_fire), .en_i(ser_en),
    .x_i(sa_q[0]), .y_i(sb_q[0]), .bit_o(ab_bit), .word_o(ab_word)
  );
  // b - a
  cvps_bitsub u_ba (
    .clk_i, .rst_ni, .clr_i(s_fire), .en_i(ser_en),
    .x_i(sb_q[0]), .y_i(sa_q[0]), .bit_o(ba_bit), .word_o()
  );
  // a - b - deadband
  cvps_bitsub u_abd (
    .clk_i, .rst_ni, .clr_i(s_fire), .en_i(ser_en),
    .x_i(ab_bit), .y_i(sd_q[0]), .bit_o(), .word_o(abd_word)
  );
  // b - a - deadband
  cvps_bitsub u_bad (
    .clk_i, .rst_ni, .clr_i(s_fire), .en_i(ser_en),
    .x_i(ba_bit), .y_i(sd_q[0]), .bit_o(), .word_o(bad_word)
  );
  // open_pressure_a - deadband
  cvps_bitsub u_dena (
    .clk_i, .rst_ni, .clr_i(s_fire), .en_i(ser_en),
    .x_i(soa_q[0]), .y_i(sd_q[0]), .bit_o(), .word_o(dena_word)
  );
  // open_pressure_b - deadband
  cvps_bitsub u_denb (
    .clk_i, .rst_ni, .clr_i(s_fire), .en_i(ser_en),
    .x_i(sob_q[0]), .y_i(sd_q[0]), .bit_o(), .word_o(denb_word)
  );

  // rate times time step
  logic [cvps_pkg::PROD_W-1:0] prod;

  cvps_mul u_mul (
    .clk_i, .rst_ni,
    .start_i(s_fire),
    .rate_i(rate_limit_q),
    .dt_i(time_step),
    .prod_o(prod)
  );

  // branch decision
  logic                  dec_zero, dec_pos, dec_ge_db, den_ok, exc_ge_den, need_div;
  logic [SW-1:0]         exc;
  logic [SW-1:0]         den;
  cvps_pkg::flags_t      flags_q, flags_d;
  logic                  hold_in_q, hold_in_d;

  always_comb begin
    dec_zero   = (ab_word == '0);
    dec_pos    = !ab_word[SW-1] && !dec_zero;
    exc        = ab_word[SW-1] ? bad_word : abd_word;
    den        = dec_pos ? dena_word : denb_word;
    dec_ge_db  = !exc[SW-1];
    den_ok     = !den[SW-1] && (den != '0);
    exc_ge_den = exc >= den;
    need_div   = dec_ge_db && !dec_zero && den_ok && !exc_ge_den;
  end

  assign div_start = (state_q == cvps_pkg::ST_DECIDE) && need_div;

  logic [cvps_pkg::QUO_W-1:0] quo;

  cvps_div u_div (
    .clk_i, .rst_ni,
    .start_i(div_start),
    .num_i(exc[cvps_pkg::PRESS_W-1:0]),
    .den_i(den[cvps_pkg::PRESS_W-1:0]),
    .busy_o(div_busy),
    .quo_o(quo)
  );

  always_comb begin
    hold_in_d = hold_in_q;
    flags_d   = flags_q;
    if (s_fire) begin
      hold_in_d = drop_a[cvps_pkg::DROP_W-1] && drop_b[cvps_pkg::DROP_W-1];
    end
    if (state_q == cvps_pkg::ST_DECIDE) begin
      flags_d.hold  = hold_in_q;
      flags_d.ge_db = dec_ge_db;
      flags_d.pos   = dec_pos;
      flags_d.zero  = dec_zero;
      flags_d.sat   = !den_ok || exc_ge_den;
    end
  end

  // target and rate clamp
  logic [PW-1:0]    valve_position_q, valve_position_d;
  logic [PW-1:0]    target_q, target_d;
  logic [PW-1:0]    offset;
  logic [PW-1:0]    base;
  logic [cvps_pkg::LIM_W-1:0] prev_ext, md_ext, lo_diff, hi_sum;
  logic [PW-1:0]    lo, hi, clamped, fail_pos, new_pos;
  logic             new_hold;

  always_comb begin
    offset = flags_q.sat ? cvps_pkg::POS_HALF : {{(PW - cvps_pkg::QUO_W){1'b0}}, quo};
    if (!flags_q.ge_db) begin
      base = cvps_pkg::POS_HALF;
    end else if (flags_q.pos) begin
      base = cvps_pkg::POS_HALF + offset;
    end else if (!flags_q.zero) begin
      base = cvps_pkg::POS_HALF - offset;
    end else begin
      base = valve_position_q;
    end
    if (flags_q.hold) begin
      target_d = valve_position_q;
    end else if (path_b_open_q) begin
      target_d = cvps_pkg::POS_FULL - base;
    end else begin
      target_d = base;
    end
  end

  always_comb begin
    prev_ext = {{(cvps_pkg::LIM_W - PW){1'b0}}, valve_position_q};
    md_ext   = {1'b0, prod[cvps_pkg::PROD_W-1:cvps_pkg::DT_FRAC]};
    lo_diff  = prev_ext - md_ext;
    hi_sum   = prev_ext + md_ext;
    lo       = (prev_ext > md_ext) ? lo_diff[PW-1:0] : '0;
    hi       = (hi_sum >= {{(cvps_pkg::LIM_W - PW){1'b0}}, cvps_pkg::POS_FULL})
             ? cvps_pkg::POS_FULL : hi_sum[PW-1:0];
    if (target_q < lo) begin
      clamped = lo;
    end else if (target_q > hi) begin
      clamped = hi;
    end else begin
      clamped = target_q;
    end
    fail_pos = (fail_to_position_q > cvps_pkg::POS_FULL) ? cvps_pkg::POS_FULL
             : fail_to_position_q;
    if (stuck_enable_q) begin
      new_pos = valve_position_q;
    end else if (fail_to_enable_q) begin
      new_pos = fail_pos;
    end else begin
      new_pos = clamped;
    end
    new_hold = flags_q.hold && !stuck_enable_q && !fail_to_enable_q;
  end

  // fsm
  always_comb begin
    state_d   = state_q;
    ser_cnt_d = ser_cnt_q;
    lim_fire  = 1'b0;
    case (state_q)
      cvps_pkg::ST_IDLE: begin
        if (s_fire) begin
          state_d   = cvps_pkg::ST_SERIAL;
          ser_cnt_d = '0;
        end
      end
      cvps_pkg::ST_SERIAL: begin
        ser_cnt_d = ser_cnt_q + 1'b1;
        if (ser_cnt_q == cvps_pkg::SER_CNT_W'(SW - 1)) begin
          state_d = cvps_pkg::ST_DECIDE;
        end
      end
      cvps_pkg::ST_DECIDE: begin
        state_d = need_div ? cvps_pkg::ST_DIVIDE : cvps_pkg::ST_TARGET;
      end
      cvps_pkg::ST_DIVIDE: begin
        if (!div_busy) begin
          state_d = cvps_pkg::ST_TARGET;
        end
      end
      cvps_pkg::ST_TARGET: begin
        state_d = cvps_pkg::ST_LIMIT;
      end
      cvps_pkg::ST_LIMIT: begin
        if (out_free) begin
          lim_fire = 1'b1;
          state_d  = cvps_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = cvps_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    valve_position_d = lim_fire ? new_pos : valve_position_q;
  end

  // output beat register
  logic                 out_valid_q, out_valid_d;
  logic [PW-1:0]        out_pos_q, out_pos_d;
  logic                 out_hold_q, out_hold_d;

  always_comb begin
    out_valid_d = out_valid_q;
    out_pos_d   = out_pos_q;
    out_hold_d  = out_hold_q;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    if (lim_fire) begin
      out_valid_d = 1'b1;
      out_pos_d   = new_pos;
      out_hold_d  = new_hold;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= cvps_pkg::ST_IDLE;
      ser_cnt_q        <= '0;
      valve_position_q <= cvps_pkg::POS_HALF;
      out_valid_q      <= 1'b0;
    end else begin
      state_q          <= state_d;
      ser_cnt_q        <= ser_cnt_d;
      valve_position_q <= valve_position_d;
      out_valid_q      <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_in_q  <= hold_in_d;
    flags_q    <= flags_d;
    target_q   <= (state_q == cvps_pkg::ST_TARGET) ? target_d : target_q;
    out_pos_q  <= out_pos_d;
    out_hold_q <= out_hold_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(cvps_pkg::M_TDATA_W - PW){1'b0}}, out_pos_q};
  assign m_axis_tuser_o  = out_hold_q;

endmodule

// ----- rtl/cvps_chk.sv -----
module cvps_chk (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid_i,
  input logic                              s_axis_tready_o,
  input logic [cvps_pkg::M_TDATA_W-1:0]    m_axis_tdata_o,
  input logic [cvps_pkg::M_TUSER_W-1:0]    m_axis_tuser_o,
  input logic                              m_axis_tvalid_o,
  input logic                              m_axis_tready_i
);

  logic s_fire;

  assign s_fire = s_axis_tvalid_i && s_axis_tready_o;

  // busy right after a beat is taken
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> !s_axis_tready_o)
    else $error("input taken again right after a beat");

  // input stays busy until the shortest pass is over
  a_min_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |-> ##37 !s_axis_tready_o)
    else $error("input ready before the serial pass finished");

  // a result only comes out of a running item
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(!s_axis_tready_o))
    else $error("result beat without an item in work");

  a_position_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[cvps_pkg::POS_W-1:0] <= cvps_pkg::POS_FULL))
    else $error("position above fully open");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("stalled result beat changed");

endmodule

bind check_valve_position_step cvps_chk u_cvps_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i)
);

// ----- test/valve_step_checker.sv -----
module valve_step_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [cvps_pkg::S_TDATA_W-1:0]  s_tdata_i,
  input  logic                          s_tvalid_i,
  input  logic                          s_tready_i,
  input  logic [cvps_pkg::M_TDATA_W-1:0]  m_tdata_i,
  input  logic [cvps_pkg::M_TUSER_W-1:0]  m_tuser_i,
  input  logic                          m_tvalid_i,
  input  logic                          m_tready_i,
  input  logic                          cfg_we_i,
  input  logic [cvps_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [cvps_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                            mismatches_o,
  output int                            outstanding_o
);
  import cvps_pkg::*;

  typedef longint unsigned u64_t;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic             backflow_hold;
  } valve_result_t;

  // shadow copy of the block's registers and stored position
  logic               b_open;
  logic [PRESS_W-1:0] open_a;
  logic [PRESS_W-1:0] open_b;
  logic [PRESS_W-1:0] deadband;
  logic [RATE_W-1:0]  rate;
  logic               stuck;
  logic               fail_to;
  logic [POS_W-1:0]   fail_pos;
  logic [POS_W-1:0]   valve_pos;

  valve_result_t expected_positions[$];

  // offset from half open for a drop excess beyond the deadband
  function automatic u64_t half_offset(u64_t excess, u64_t open_p);
    u64_t q;
    if (open_p <= u64_t'(deadband)) return u64_t'(POS_HALF);
    q = (excess * u64_t'(POS_HALF)) / (open_p - u64_t'(deadband));
    return (q >= u64_t'(POS_HALF)) ? u64_t'(POS_HALF) : q;
  endfunction

  function automatic valve_result_t next_position(logic signed [DROP_W-1:0] a,
                                                  logic signed [DROP_W-1:0] b,
                                                  logic [DT_W-1:0] dt);
    longint        sa;
    longint        sb;
    longint        diff;
    u64_t          mag;
    u64_t          target;
    u64_t          prev;
    u64_t          max_delta;
    u64_t          lo;
    u64_t          hi;
    valve_result_t r;
    r.backflow_hold = 1'b0;
    r.position = valve_pos;
    if (stuck) begin
      r.position = valve_pos;
    end else if (fail_to) begin
      r.position = (fail_pos > POS_FULL) ? POS_FULL : fail_pos;
    end else begin
      prev = u64_t'(valve_pos);
      sa = a;
      sb = b;
      if (sa < 0 && sb < 0) begin
        target = prev;
        r.backflow_hold = 1'b1;
      end else begin
        diff = sa - sb;
        mag = (diff < 0) ? u64_t'(-diff) : u64_t'(diff);
        if (mag < u64_t'(deadband)) begin
          target = u64_t'(POS_HALF);
        end else if (diff > 0) begin
          target = u64_t'(POS_HALF) + half_offset(mag - u64_t'(deadband), u64_t'(open_a));
        end else if (diff < 0) begin
          target = u64_t'(POS_HALF) - half_offset(mag - u64_t'(deadband), u64_t'(open_b));
        end else begin
          target = prev;
        end
        if (b_open) target = u64_t'(POS_FULL) - target;
      end
      max_delta = (u64_t'(rate) * u64_t'(dt)) >> DT_FRAC;
      lo = (prev > max_delta) ? prev - max_delta : 0;
      hi = (prev + max_delta >= u64_t'(POS_FULL)) ? u64_t'(POS_FULL) : prev + max_delta;
      if (target < lo) target = lo;
      if (target > hi) target = hi;
      r.position = target[POS_W-1:0];
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    valve_result_t want;
    valve_result_t got;
    if (!rst_ni) begin
      b_open    = 1'b0;
      open_a    = OPEN_PRESSURE_RST;
      open_b    = OPEN_PRESSURE_RST;
      deadband  = DEADBAND_RST;
      rate      = RATE_LIMIT_RST;
      stuck     = 1'b0;
      fail_to   = 1'b0;
      fail_pos  = '0;
      valve_pos = POS_HALF;
      expected_positions.delete();
      mismatches_o  = 0;
      outstanding_o = 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        got.position = m_tdata_i[POS_W-1:0];
        got.backflow_hold = m_tuser_i[0];
        if (expected_positions.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual position %0d hold %0d",
                   $time, got.position, got.backflow_hold);
          mismatches_o++;
        end else begin
          want = expected_positions.pop_front();
          if (got.position !== want.position) begin
            $display("%0t: position expected %0d actual %0d",
                     $time, want.position, got.position);
            mismatches_o++;
          end
          if (got.backflow_hold !== want.backflow_hold) begin
            $display("%0t: backflow_hold expected %0d actual %0d",
                     $time, want.backflow_hold, got.backflow_hold);
            mismatches_o++;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PATH_B_OPEN:      b_open   = cfg_data_i[0];
          CFG_OPEN_PRESSURE_A:  open_a   = cfg_data_i[PRESS_W-1:0];
          CFG_OPEN_PRESSURE_B:  open_b   = cfg_data_i[PRESS_W-1:0];
          CFG_DEADBAND:         deadband = cfg_data_i[PRESS_W-1:0];
          CFG_RATE_LIMIT:       rate     = cfg_data_i[RATE_W-1:0];
          CFG_STUCK_ENABLE:     stuck    = cfg_data_i[0];
          CFG_FAIL_TO_ENABLE:   fail_to  = cfg_data_i[0];
          CFG_FAIL_TO_POSITION: fail_pos = cfg_data_i[POS_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i) begin
        want = next_position(s_tdata_i[31:0], s_tdata_i[63:32], s_tdata_i[84:64]);
        valve_pos = want.position;
        expected_positions.push_back(want);
      end
      outstanding_o = expected_positions.size();
    end
  end

endmodule

// ----- test/tb_check_valve_position_step.sv -----
module tb_check_valve_position_step;
  import cvps_pkg::*;

  localparam int QUIET_LIMIT  = 2000;
  localparam int RANDOM_ITEMS = 1180;
  localparam int CALM_ITEMS   = 100;

  logic                   clk_i;
  logic                   rst_ni;
  logic [S_TDATA_W-1:0]   s_tdata;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [M_TDATA_W-1:0]   m_tdata;
  logic [M_TUSER_W-1:0]   m_tuser;
  logic                   m_tvalid;
  logic                   m_tready;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_idx;
  logic [CFG_DATA_W-1:0]  cfg_data;

  int   mismatches;
  int   outstanding;
  int   quiet_cycles;
  logic idle_on;
  int   stall_left;
  int   items_sent;
  int unsigned drop_span;

  check_valve_position_step u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data)
  );

  valve_step_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_tdata_i     (s_tdata),
    .s_tvalid_i    (s_tvalid),
    .s_tready_i    (s_tready),
    .m_tdata_i     (m_tdata),
    .m_tuser_i     (m_tuser),
    .m_tvalid_i    (m_tvalid),
    .m_tready_i    (m_tready),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // receive side with random stall bursts
  initial begin
    m_tready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        m_tready = 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        m_tready = 1'b0;
        stall_left = $urandom_range(1, 12) - 1;
      end else begin
        m_tready = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_beat(logic [31:0] a, logic [31:0] b, logic [DT_W-1:0] dt);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
    s_tdata  = {3'b000, dt, b, a};
    s_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_tready);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    s_tvalid = 1'b0;
    while (outstanding != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] value);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = value;
    @(negedge clk_i);
    cfg_we   = 1'b0;
  endtask

  function automatic logic [PRESS_W-1:0] pick_pressure();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 31'h7fffffff;
      2:       return 31'($urandom());
      3:       return 31'($urandom_range(1, 300));
      default: return 31'($urandom_range(1000, 200000));
    endcase
  endfunction

  function automatic logic [PRESS_W-1:0] pick_deadband();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 31'h7fffffff;
      2:       return 31'($urandom());
      default: return 31'($urandom_range(0, 2000));
    endcase
  endfunction

  task automatic pick_settings();
    logic [PRESS_W-1:0] opa;
    logic [PRESS_W-1:0] opb;
    logic [PRESS_W-1:0] db;
    logic [RATE_W-1:0]  rate;
    longint             span;
    opa = pick_pressure();
    opb = pick_pressure();
    db  = pick_deadband();
    case ($urandom_range(0, 7))
      0:       rate = '0;
      1:       rate = 24'hffffff;
      2:       rate = 24'($urandom());
      default: rate = 24'($urandom_range(1000, 300000));
    endcase
    write_reg(CFG_PATH_B_OPEN, 31'($urandom_range(0, 1)));
    write_reg(CFG_OPEN_PRESSURE_A, opa);
    write_reg(CFG_OPEN_PRESSURE_B, opb);
    write_reg(CFG_DEADBAND, db);
    write_reg(CFG_RATE_LIMIT, 31'(rate));
    write_reg(CFG_STUCK_ENABLE, 31'($urandom_range(0, 9) == 0));
    write_reg(CFG_FAIL_TO_ENABLE, 31'($urandom_range(0, 7) == 0));
    write_reg(CFG_FAIL_TO_POSITION, 31'($urandom_range(0, 131071)));
    // keep most drops near the interesting pressures of this setting
    span = (opa > opb) ? longint'(opa) : longint'(opb);
    span = span + longint'(db) + 16;
    drop_span = (span > 64'h4000_0000) ? 32'h4000_0000 : 32'(span);
  endtask

  function automatic logic [31:0] gen_drop();
    case ($urandom_range(0, 5))
      0:       return $urandom();
      1:       return -$urandom_range(0, 2000);
      2, 3:    return $urandom_range(0, drop_span);
      default: return -$urandom_range(0, drop_span);
    endcase
  endfunction

  function automatic logic [DT_W-1:0] gen_step();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 21'h100000;
      2:       return 21'($urandom());
      3:       return 21'h1fffff;
      default: return 21'($urandom_range(0, 21'h100000));
    endcase
  endfunction

  task automatic random_phase(int count);
    logic [31:0] a;
    logic [31:0] b;
    repeat (count) begin
      a = gen_drop();
      b = gen_drop();
      case ($urandom_range(0, 9))
        0: b = a;
        1: begin
          a[31] = 1'b1;
          b[31] = 1'b1;
        end
        default: ;
      endcase
      send_beat(a, b, gen_step());
      items_sent++;
    end
  endtask

  initial begin
    rst_ni     = 1'b0;
    s_tdata    = '0;
    s_tvalid   = 1'b0;
    cfg_we     = 1'b0;
    cfg_idx    = CFG_PATH_B_OPEN;
    cfg_data   = '0;
    idle_on    = 1'b1;
    items_sent = 0;
    drop_span  = 32'd60000;
    quiet_cycles = 0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset settings: extremes, backflow, deadband, linear in both directions
    send_beat(32'd0, 32'd0, 21'd0);
    send_beat(32'h7fffffff, 32'h80000000, 21'h100000);
    send_beat(32'h80000000, 32'h7fffffff, 21'h1fffff);
    send_beat(32'hffffffff, 32'hffffffff, 21'h100000);
    send_beat(32'h80000000, 32'hfffffffb, 21'h1fffff);
    send_beat(32'd100, 32'd0, 21'h100000);
    send_beat(32'd12800, 32'd0, 21'h100000);
    send_beat(32'd0, 32'd12800, 21'h100000);
    send_beat(32'd5000, 32'd5000, 21'h080000);
    drain_results();

    // zero deadband, mirrored sense, fastest rate
    write_reg(CFG_DEADBAND, '0);
    write_reg(CFG_PATH_B_OPEN, 31'd1);
    write_reg(CFG_RATE_LIMIT, 31'hffffff);
    send_beat(32'd7, 32'd7, 21'h1fffff);
    send_beat(32'd300, 32'd0, 21'h1fffff);
    send_beat(32'd0, 32'd300, 21'h1fffff);
    send_beat(32'hfffffed4, 32'hffffffff, 21'h1fffff);
    drain_results();

    // open pressure not above the deadband
    write_reg(CFG_PATH_B_OPEN, '0);
    write_reg(CFG_DEADBAND, 31'd10);
    write_reg(CFG_OPEN_PRESSURE_A, 31'd5);
    write_reg(CFG_OPEN_PRESSURE_B, 31'd10);
    send_beat(32'd100, 32'd0, 21'h1fffff);
    send_beat(32'd0, 32'd100, 21'h1fffff);
    send_beat(32'd11, 32'd0, 21'h000100);
    drain_results();

    // stuck wins over fail-to, then fail-to saturates
    write_reg(CFG_STUCK_ENABLE, 31'd1);
    write_reg(CFG_FAIL_TO_ENABLE, 31'd1);
    write_reg(CFG_FAIL_TO_POSITION, 31'd131071);
    send_beat(32'd100, 32'd0, 21'h1fffff);
    send_beat(32'hffffffff, 32'hfffffff0, 21'h100000);
    drain_results();
    write_reg(CFG_STUCK_ENABLE, '0);
    send_beat(32'd0, 32'd100, 21'h100000);
    drain_results();
    write_reg(CFG_FAIL_TO_POSITION, '0);
    write_reg(CFG_FAIL_TO_POSITION, 31'd65536);
    send_beat(32'd0, 32'd0, 21'd0);
    drain_results();

    // zero rate holds the position
    write_reg(CFG_FAIL_TO_ENABLE, '0);
    write_reg(CFG_RATE_LIMIT, '0);
    send_beat(32'd0, 32'd1000, 21'h1fffff);
    drain_results();

    while (items_sent < RANDOM_ITEMS) begin
      pick_settings();
      idle_on = ($urandom_range(0, 3) != 0);
      random_phase($urandom_range(60, 140));
      drain_results();
    end

    // final stretch without idling on either side
    pick_settings();
    write_reg(CFG_STUCK_ENABLE, '0);
    write_reg(CFG_FAIL_TO_ENABLE, '0);
    idle_on = 1'b0;
    random_phase(CALM_ITEMS);
    drain_results();
    repeat (80) @(negedge clk_i);

    if (mismatches == 0 && outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
